// ===== rtl/sctpg_pkg.sv =====
// Shared constants, types and font/layout functions for the clock text pixel generator.
package sctpg_pkg;

    // Screen geometry in pixels.
    localparam int DISPLAY_WIDTH  = 800;
    localparam int DISPLAY_HEIGHT = 480;

    // Font and string layout.
    localparam int SCALE_W     = 5;
    localparam int SCALE_LO    = 8;
    localparam int SCALE_HI    = 22;
    localparam int TEXT_COLS   = 43;
    localparam int GLYPH_ROWS  = 7;
    localparam int PIX_PER_BYTE = 8;
    localparam int NUM_DIGITS  = 6;

    localparam int SCALE_RESET_RAW = DISPLAY_WIDTH / 46;
    localparam int SCALE_RESET = (SCALE_RESET_RAW < SCALE_LO) ? SCALE_LO :
                                 (SCALE_RESET_RAW > SCALE_HI) ? SCALE_HI : SCALE_RESET_RAW;

    // Signed widths for horizontal and vertical offsets from the text origin.
    localparam int XW = $clog2(DISPLAY_WIDTH + 2048) + 1;
    localparam int YW = $clog2(DISPLAY_HEIGHT + 2048) + 1;

    // Horizontal offset into the text once it is known to hit: below 43 * 22.
    localparam int UW = 10;
    localparam int CW = 6;

    // Reciprocal of the scale, scaled by 2^RECIP_SHIFT and rounded up.
    localparam int RECIP_W     = 14;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = UW + RECIP_W;

    // Queue depths.
    localparam int CMDQ_DEPTH = 2;
    localparam int OUT_DEPTH  = 4;

    typedef logic [SCALE_W-1:0]       scale_t;
    typedef logic [3:0]               digit_t;
    typedef logic signed [XW-1:0]     xpos_t;
    typedef logic signed [YW-1:0]     ypos_t;

    localparam digit_t COLON_CODE = 4'd10;
    localparam scale_t SCALE_RESET_VAL = scale_t'(SCALE_RESET);

    // One classified request as it travels from the front end to the renderer.
    typedef struct packed {
        logic                   draw;     // row inside the text band and x window hits
        logic [2:0]             gy;       // font row
        logic [UW-1:0]          u_pos;    // offset of the first pixel into the text
        logic signed [3:0]      neg_off;  // first pixel left of the text by this much
        logic [PIX_PER_BYTE-1:0] vis;     // pixel lies on the screen, bit 7 leftmost
        digit_t [NUM_DIGITS-1:0] digits;  // HH MM SS digits, index 0 leftmost
    } cmd_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] slot;
        logic [2:0] gx;
    } colmap_t;

    localparam logic [4:0] GLYPH_ROM [0:10][0:6] = '{
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
        '{5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00}
    };

    function automatic scale_t eff_scale(input scale_t s);
        scale_t r;
        if (s < scale_t'(SCALE_LO))
        begin
            r = scale_t'(SCALE_LO);
        end
        else if (s > scale_t'(SCALE_HI))
        begin
            r = scale_t'(SCALE_HI);
        end
        else
        begin
            r = s;
        end
        return r;
    endfunction

    // Half of (width - span), rounded toward zero like C integer division.
    function automatic xpos_t text_x0(input scale_t s);
        logic signed [XW+1:0] d;
        logic signed [XW+1:0] d_adj;
        d = $signed((XW+2)'(DISPLAY_WIDTH)) - $signed((XW+2)'(s) * (XW+2)'(TEXT_COLS));
        d_adj = d + $signed({{(XW+1){1'b0}}, d[XW+1]});
        return xpos_t'(d_adj >>> 1);
    endfunction

    function automatic ypos_t text_y0(input scale_t s);
        logic signed [YW+1:0] d;
        logic signed [YW+1:0] d_adj;
        d = $signed((YW+2)'(DISPLAY_HEIGHT)) - $signed((YW+2)'(s) * (YW+2)'(GLYPH_ROWS));
        d_adj = d + $signed({{(YW+1){1'b0}}, d[YW+1]});
        return ypos_t'(d_adj >>> 1);
    endfunction

    function automatic logic [RECIP_W-1:0] recip_of(input scale_t s);
        logic [RECIP_W-1:0] r;
        case (s)
            5'd8:    r = 14'd8192;
            5'd9:    r = 14'd7282;
            5'd10:   r = 14'd6554;
            5'd11:   r = 14'd5958;
            5'd12:   r = 14'd5462;
            5'd13:   r = 14'd5042;
            5'd14:   r = 14'd4682;
            5'd15:   r = 14'd4370;
            5'd16:   r = 14'd4096;
            5'd17:   r = 14'd3856;
            5'd18:   r = 14'd3641;
            5'd19:   r = 14'd3450;
            5'd20:   r = 14'd3277;
            5'd21:   r = 14'd3121;
            5'd22:   r = 14'd2979;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic digit_t tens_of(input logic [5:0] v);
        digit_t t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    function automatic digit_t units_of(input logic [5:0] v);
        logic [5:0] t;
        t = 6'(tens_of(v));
        return digit_t'(v - t * 6'd10);
    endfunction

    // Text column (in font dots) to character slot and dot column inside it.
    function automatic colmap_t col_map(input logic [CW-1:0] col);
        colmap_t    m;
        logic [CW-1:0] base;
        m.hit  = 1'b1;
        m.slot = 3'd0;
        base   = '0;
        case (col) inside
            [6'd0:6'd4]:
            begin
                m.slot = 3'd0;
                base   = 6'd0;
            end
            [6'd6:6'd10]:
            begin
                m.slot = 3'd1;
                base   = 6'd6;
            end
            [6'd12:6'd14]:
            begin
                m.slot = 3'd2;
                base   = 6'd12;
            end
            [6'd16:6'd20]:
            begin
                m.slot = 3'd3;
                base   = 6'd16;
            end
            [6'd22:6'd26]:
            begin
                m.slot = 3'd4;
                base   = 6'd22;
            end
            [6'd28:6'd30]:
            begin
                m.slot = 3'd5;
                base   = 6'd28;
            end
            [6'd32:6'd36]:
            begin
                m.slot = 3'd6;
                base   = 6'd32;
            end
            [6'd38:6'd42]:
            begin
                m.slot = 3'd7;
                base   = 6'd38;
            end
            default:
            begin
                m.hit = 1'b0;
            end
        endcase
        m.gx = 3'(col - base);
        return m;
    endfunction

    function automatic digit_t slot_code(input digit_t [NUM_DIGITS-1:0] d,
                                         input logic [2:0] slot);
        digit_t c;
        case (slot)
            3'd0:    c = d[0];
            3'd1:    c = d[1];
            3'd3:    c = d[2];
            3'd4:    c = d[3];
            3'd6:    c = d[4];
            3'd7:    c = d[5];
            default: c = COLON_CODE;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] glyph_row(input digit_t code, input logic [2:0] gy);
        logic [4:0] r;
        r = '0;
        if (code <= COLON_CODE && gy < 3'(GLYPH_ROWS))
        begin
            r = GLYPH_ROM[code][gy];
        end
        return r;
    endfunction

endpackage

// ===== rtl/scaled_clock_text_pixel_generator_core.sv =====
// Top level of the scaled clock text pixel generator.
//
// Renders one framebuffer byte of the string HH:MM:SS, drawn in a 5x7 font
// magnified by glyph_scale and centered on an 800 by 480 one-bit display.
// Requests enter through a queue-style port: a request is taken on a clock
// edge where push is high and full is low. Each request carries the time and
// the row and byte column of the wanted byte. Results leave the same way: the
// oldest byte sits on pixel_byte while empty is low and is consumed on an edge
// where pop is high. Bit 7 is the leftmost pixel and 1 means ink.
// The scale register is written over its own valid/ready channel, which is
// always ready; write it only when no request is outstanding.
// One request per cycle is sustained while the receiver keeps popping: the
// renderer issues whenever its result queue has a free slot, so a stalled
// receiver fills the result queue, then the two-entry request queue, and
// then raises full. Reset empties both queues and restores the scale to 17;
// a scale outside 8 to 22 is used as the nearer bound.
module scaled_clock_text_pixel_generator_core
    import sctpg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] glyph_scale,
    input  logic       push,
    output logic       full,
    input  logic [4:0] hours,
    input  logic [5:0] minutes,
    input  logic [5:0] seconds,
    input  logic [8:0] row,
    input  logic [6:0] byte_column,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] pixel_byte
);

    scale_t glyph_scale_reg;
    cmd_t   front_cmd;
    cmd_t   queued_cmd;
    logic   queued_valid;
    logic   back_take;

    // The scale register is the only configuration; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_scale_reg <= SCALE_RESET_VAL;
        end
        else if (cfg_valid)
        begin
            glyph_scale_reg <= glyph_scale;
        end
    end

    // Front end classifies the request in the cycle it arrives.
    sctpg_front u_front (
        .scale       (glyph_scale_reg),
        .hours       (hours),
        .minutes     (minutes),
        .seconds     (seconds),
        .row         (row),
        .byte_column (byte_column),
        .cmd         (front_cmd)
    );

    // Classified requests wait here until the renderer has room.
    sctpg_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_cmd   (front_cmd),
        .full     (full),
        .rd_en    (back_take),
        .rd_valid (queued_valid),
        .rd_cmd   (queued_cmd)
    );

    // Renderer pipeline and result queue.
    sctpg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .scale      (glyph_scale_reg),
        .cmd_valid  (queued_valid),
        .cmd        (queued_cmd),
        .cmd_take   (back_take),
        .empty      (empty),
        .pop        (pop),
        .pixel_byte (pixel_byte)
    );

endmodule

// ===== rtl/sctpg_front.sv =====
// Front end: classifies a request against the text box and splits the time into digits.
module sctpg_front
    import sctpg_pkg::*;
(
    input  scale_t     scale,
    input  logic [4:0] hours,
    input  logic [5:0] minutes,
    input  logic [5:0] seconds,
    input  logic [8:0] row,
    input  logic [6:0] byte_column,
    output cmd_t       cmd
);

    scale_t        s;
    xpos_t         x0;
    ypos_t         y0;
    logic [9:0]    x_base;
    xpos_t         u0;
    xpos_t         u0_p7;
    xpos_t         text_w;
    ypos_t         w;
    ypos_t         text_h;
    logic          hit_x;
    logic          row_ok;
    logic [2:0]    gy;

    assign s      = eff_scale(scale);
    assign x0     = text_x0(s);
    assign y0     = text_y0(s);
    assign x_base = {byte_column, 3'b000};

    assign u0     = $signed(XW'(x_base)) - x0;
    assign u0_p7  = u0 + $signed(XW'(7));
    assign text_w = $signed(XW'(s) * XW'(TEXT_COLS));
    // The byte touches the text if some pixel of it lies in [0, 43*scale).
    assign hit_x  = !u0_p7[XW-1] && (u0 < text_w);

    assign w      = $signed(YW'(row)) - y0;
    assign text_h = $signed(YW'(s) * YW'(GLYPH_ROWS));
    assign row_ok = (32'(row) < DISPLAY_HEIGHT) && !w[YW-1] && (w < text_h);

    // Font row: number of whole scale steps below the row offset.
    always_comb
    begin
        gy = 3'd0;
        for (int k = 1; k < GLYPH_ROWS; k++)
        begin
            if (w >= $signed(YW'(s) * YW'(k)))
            begin
                gy = gy + 3'd1;
            end
        end
    end

    always_comb
    begin
        cmd.draw    = hit_x && row_ok;
        cmd.gy      = gy;
        cmd.u_pos   = (hit_x && !u0[XW-1]) ? UW'(u0) : '0;
        cmd.neg_off = (hit_x && u0[XW-1]) ? 4'(u0) : 4'sd0;
        for (int b = 0; b < PIX_PER_BYTE; b++)
        begin
            cmd.vis[PIX_PER_BYTE-1-b] = (32'(x_base) + 32'(b)) < DISPLAY_WIDTH;
        end
        cmd.digits[0] = tens_of(6'(hours));
        cmd.digits[1] = units_of(6'(hours));
        cmd.digits[2] = tens_of(minutes);
        cmd.digits[3] = units_of(minutes);
        cmd.digits[4] = tens_of(seconds);
        cmd.digits[5] = units_of(seconds);
    end

endmodule

// ===== rtl/sctpg_cmd_queue.sv =====
// Short queue of classified requests between the front end and the renderer.
module sctpg_cmd_queue
    import sctpg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic rd_en,
    output logic rd_valid,
    output cmd_t rd_cmd
);

    localparam int PW = $clog2(CMDQ_DEPTH);
    localparam int NW = $clog2(CMDQ_DEPTH + 1);

    cmd_t          mem [CMDQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full     = (count_reg == NW'(CMDQ_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + NW'(do_wr) - NW'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== rtl/sctpg_back.sv =====
// Back end: locates the text column of each pixel, reads the font and queues result bytes.
module sctpg_back
    import sctpg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  scale_t     scale,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_take,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] pixel_byte
);

    localparam int OCC_W = $clog2(OUT_DEPTH + 1);
    localparam int OPW   = $clog2(OUT_DEPTH);

    scale_t              s;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic                deq;
    logic [PROD_W-1:0]   prod;

    logic                s1_valid_reg;
    cmd_t                s1_cmd_reg;
    logic [CW-1:0]       s1_c0_reg;

    logic [10:0]         c0_times_s;
    logic signed [11:0]  r0_full;
    logic                s2_valid_reg;
    cmd_t                s2_cmd_reg;
    logic [CW-1:0]       s2_c0_reg;
    logic signed [5:0]   s2_r0_reg;

    logic [7:0]          pix;
    logic [7:0]          out_mem [OUT_DEPTH];
    logic [OPW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [OCC_W-1:0]    out_count_reg, out_count_next;

    // Ink for pixel b of the byte, given the column and remainder of its first pixel.
    function automatic logic pixel_on(input cmd_t c, input logic [CW-1:0] c0,
                                      input logic signed [5:0] r0, input scale_t sc,
                                      input int b);
        logic signed [6:0] rr;
        logic [CW-1:0]     col;
        colmap_t           cm;
        digit_t            code;
        logic [4:0]        bits;
        rr   = 7'(r0) + 7'(b);
        col  = c0 + CW'(rr >= $signed({2'b00, sc}));
        cm   = col_map(col);
        code = slot_code(c.digits, cm.slot);
        bits = glyph_row(code, c.gy);
        return c.draw && !rr[6] && cm.hit && bits[3'd4 - cm.gx];
    endfunction

    assign s        = eff_scale(scale);
    assign deq      = pop && !empty;
    // Every request in flight already owns a slot in the result queue.
    assign cmd_take = cmd_valid && (occ_reg < OCC_W'(OUT_DEPTH));
    assign occ_next = occ_reg + OCC_W'(cmd_take) - OCC_W'(deq);

    // Stage 1: text column of the first pixel by reciprocal multiplication.
    assign prod = PROD_W'(cmd.u_pos) * PROD_W'(recip_of(s));

    // Stage 2: remainder within that column, shifted left when the byte starts early.
    assign c0_times_s = 11'(s1_c0_reg) * 11'(s);
    assign r0_full    = $signed(12'(s1_cmd_reg.u_pos)) - $signed(12'(c0_times_s))
                        + 12'($signed(s1_cmd_reg.neg_off));

    // Stage 3: eight pixels side by side.
    always_comb
    begin
        for (int b = 0; b < PIX_PER_BYTE; b++)
        begin
            pix[PIX_PER_BYTE-1-b] = s2_cmd_reg.vis[PIX_PER_BYTE-1-b]
                                    && pixel_on(s2_cmd_reg, s2_c0_reg, s2_r0_reg, s, b);
        end
    end

    assign out_count_next = out_count_reg + OCC_W'(s2_valid_reg) - OCC_W'(deq);
    assign empty          = (out_count_reg == '0);
    assign pixel_byte     = out_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            occ_reg       <= occ_next;
            s1_valid_reg  <= cmd_take;
            s2_valid_reg  <= s1_valid_reg;
            out_count_reg <= out_count_next;
            if (s2_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + OPW'(1);
            end
            if (deq)
            begin
                rd_ptr_reg <= rd_ptr_reg + OPW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg <= cmd;
        s1_c0_reg  <= prod[RECIP_SHIFT +: CW];
        s2_cmd_reg <= s1_cmd_reg;
        s2_c0_reg  <= s1_c0_reg;
        s2_r0_reg  <= 6'(r0_full);
        if (s2_valid_reg)
        begin
            out_mem[wr_ptr_reg] <= pix;
        end
    end

endmodule

// ===== rtl/sctpg_checker.sv =====
// Port-level checker for the clock text pixel generator, bound to the top level.
module sctpg_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] pixel_byte
);

    logic [3:0] outstanding_reg;

    // Requests taken and not yet consumed, as seen from the ports.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= 4'd0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + 4'(push && !full) - 4'(pop && !empty);
        end
    end

    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> empty)
        else $error("result queue not empty after reset");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pixel_byte)))
        else $error("waiting result changed or vanished");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (outstanding_reg != 4'd0))
        else $error("result shown with no request outstanding");

    a_full_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (outstanding_reg >= 4'd2))
        else $error("full raised with fewer than two requests outstanding");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 4'd6)
        else $error("more requests outstanding than the block can hold");

endmodule

bind scaled_clock_text_pixel_generator_core sctpg_checker u_sctpg_checker (.*);

// ===== sim/clock_text_pixel_checker.sv =====
// Checker for the clock text pixel generator: predicts every pixel byte and compares results.
module clock_text_pixel_checker
    import sctpg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [4:0] glyph_scale,
    input  logic       push,
    input  logic       full,
    input  logic [4:0] hours,
    input  logic [5:0] minutes,
    input  logic [5:0] seconds,
    input  logic [8:0] row,
    input  logic [6:0] byte_column,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] pixel_byte,
    output int         mismatch_count,
    output int         outstanding,
    output int         bytes_checked,
    output int         inked_bytes
);

    localparam int COLON_GLYPH = 10;

    // 5x7 font, bit 4 of each row is the leftmost dot; the last entry is the colon.
    localparam logic [4:0] FONT_DOTS [0:10][0:6] = '{
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
        '{5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00}
    };

    typedef struct {
        logic [7:0] pixels;
        logic [4:0] scale;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [8:0] row;
        logic [6:0] byte_column;
    } pixel_request_t;

    pixel_request_t pending_bytes[$];
    logic [4:0]     scale_reg;
    int             n_mismatch;
    int             n_checked;
    int             n_inked;

    // Renders one byte of the centered HH:MM:SS string at the given raw scale.
    function automatic logic [7:0] render_pixel_byte(input logic [4:0] raw_scale,
                                                     input logic [4:0] hh,
                                                     input logic [5:0] mm,
                                                     input logic [5:0] ss,
                                                     input logic [8:0] y_in,
                                                     input logic [6:0] col);
        int         s;
        int         x0;
        int         y0;
        int         pos;
        int         y;
        int         gy;
        int         x;
        int         dx;
        int         code [8];
        int         slot_left [8];
        logic [7:0] pix;
        logic       ink;
        s = int'(raw_scale);
        if (s < SCALE_LO)
        begin
            s = SCALE_LO;
        end
        if (s > SCALE_HI)
        begin
            s = SCALE_HI;
        end
        // Integer division in SystemVerilog truncates toward zero, so a text
        // wider than the screen gets a negative left edge as intended.
        x0 = (DISPLAY_WIDTH - 43 * s) / 2;
        y0 = (DISPLAY_HEIGHT - 7 * s) / 2;
        code[0] = int'(hh) / 10;
        code[1] = int'(hh) % 10;
        code[2] = COLON_GLYPH;
        code[3] = int'(mm) / 10;
        code[4] = int'(mm) % 10;
        code[5] = COLON_GLYPH;
        code[6] = int'(ss) / 10;
        code[7] = int'(ss) % 10;
        pos = x0;
        for (int i = 0; i < 8; i++)
        begin
            slot_left[i] = pos;
            pos += ((code[i] == COLON_GLYPH) ? 3 * s : 5 * s) + s;
        end
        pix = '0;
        y = int'(y_in);
        if (y < DISPLAY_HEIGHT && y >= y0 && y < y0 + 7 * s)
        begin
            gy = (y - y0) / s;
            for (int b = 0; b < 8; b++)
            begin
                x = int'(col) * 8 + b;
                ink = 1'b0;
                if (x < DISPLAY_WIDTH)
                begin
                    // A colon is looked up over a five-dot window too; its right
                    // columns are blank, so the overlap with the gap and the next digit adds no ink.
                    for (int i = 0; i < 8; i++)
                    begin
                        dx = x - slot_left[i];
                        if (dx >= 0 && dx < 5 * s)
                        begin
                            if (FONT_DOTS[code[i]][gy][4 - dx / s])
                            begin
                                ink = 1'b1;
                            end
                        end
                    end
                end
                pix[7 - b] = ink;
            end
        end
        return pix;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        pixel_request_t req;
        if (!rst_n)
        begin
            scale_reg = SCALE_RESET_VAL;
            pending_bytes.delete();
            n_mismatch = 0;
            n_checked = 0;
            n_inked = 0;
            mismatch_count <= 0;
            outstanding <= 0;
            bytes_checked <= 0;
            inked_bytes <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (pending_bytes.size() == 0)
                begin
                    $display("%0t: unexpected pixel byte, expected none, actual %02h",
                             $time, pixel_byte);
                    n_mismatch++;
                end
                else
                begin
                    req = pending_bytes.pop_front();
                    n_checked++;
                    if (req.pixels != 8'h00)
                    begin
                        n_inked++;
                    end
                    if (pixel_byte !== req.pixels)
                    begin
                        $write("%0t: pixel_byte mismatch, expected %02h, actual %02h ",
                               $time, req.pixels, pixel_byte);
                        $display("(scale %0d, time %0d:%0d:%0d, row %0d, column %0d)",
                                 req.scale, req.hours, req.minutes, req.seconds, req.row,
                                 req.byte_column);
                        n_mismatch++;
                    end
                end
            end
            if (push && !full)
            begin
                req.scale = scale_reg;
                req.hours = hours;
                req.minutes = minutes;
                req.seconds = seconds;
                req.row = row;
                req.byte_column = byte_column;
                req.pixels = render_pixel_byte(scale_reg, hours, minutes, seconds, row,
                                               byte_column);
                pending_bytes.push_back(req);
            end
            if (cfg_valid && cfg_ready)
            begin
                scale_reg = glyph_scale;
            end
            mismatch_count <= n_mismatch;
            outstanding <= pending_bytes.size();
            bytes_checked <= n_checked;
            inked_bytes <= n_inked;
        end
    end

endmodule

// ===== sim/tb_scaled_clock_text_pixel_generator_core.sv =====
// Testbench top for the clock text pixel generator: stimulus, idling and the verdict.
module tb_scaled_clock_text_pixel_generator_core
    import sctpg_pkg::*;
();

    // A correct run never goes this many cycles without some request, result
    // or scale write being accepted: every sender gap and receiver stall ends,
    // and a taken request always reaches the result port.
    localparam int STALL_LIMIT = 1000;
    // Settling time after the last result.
    localparam int SETTLE_CYCLES = 16;
    localparam int NUM_PHASES = 8;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic [4:0] glyph_scale;
    logic       push;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [8:0] row;
    logic [6:0] byte_column;
    logic       pop = 1'b0;
    wire        cfg_ready;
    wire        full;
    wire        empty;
    wire  [7:0] pixel_byte;

    int mismatch_count;
    int outstanding;
    int bytes_checked;
    int inked_bytes;

    // Stimulus bookkeeping: the raw scale last written, how many requests went
    // in, how many scale settings were used, and whether idling is allowed.
    int cur_scale;
    int requests_sent;
    int settings_used;
    bit idle_en;
    int pop_hold = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    scaled_clock_text_pixel_generator_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .glyph_scale (glyph_scale),
        .push        (push),
        .full        (full),
        .hours       (hours),
        .minutes     (minutes),
        .seconds     (seconds),
        .row         (row),
        .byte_column (byte_column),
        .empty       (empty),
        .pop         (pop),
        .pixel_byte  (pixel_byte)
    );

    clock_text_pixel_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .glyph_scale    (glyph_scale),
        .push           (push),
        .full           (full),
        .hours          (hours),
        .minutes        (minutes),
        .seconds        (seconds),
        .row            (row),
        .byte_column    (byte_column),
        .empty          (empty),
        .pop            (pop),
        .pixel_byte     (pixel_byte),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .bytes_checked  (bytes_checked),
        .inked_bytes    (inked_bytes)
    );

    // The receiver pops every cycle unless idling is allowed, in which case it
    // now and then stalls. Only this process drives pop, and it does so once per
    // falling edge.
    always @(negedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop_hold <= pop_hold - 1;
            pop <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            pop_hold <= $urandom_range(0, 8);
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // The scale actually used: register values outside 8 to 22 snap to the
    // nearer bound.
    function automatic int clamp_scale(input int raw);
        int s;
        s = raw;
        if (s < SCALE_LO)
        begin
            s = SCALE_LO;
        end
        if (s > SCALE_HI)
        begin
            s = SCALE_HI;
        end
        return s;
    endfunction

    // Top row of the text band and left pixel of the string for a given scale.
    function automatic int band_top(input int s);
        return (DISPLAY_HEIGHT - 7 * s) / 2;
    endfunction

    function automatic int text_left(input int s);
        return (DISPLAY_WIDTH - 43 * s) / 2;
    endfunction

    // Byte column holding a pixel, with the pixel pulled onto the screen first.
    function automatic int byte_of_pixel(input int px);
        int p;
        p = px;
        if (p < 0)
        begin
            p = 0;
        end
        if (p > DISPLAY_WIDTH - 1)
        begin
            p = DISPLAY_WIDTH - 1;
        end
        return p / 8;
    endfunction

    // Offers one request and holds it until the block takes it. Push stays
    // high afterwards so that back-to-back requests need no gap; whoever
    // stops sending lowers it. When idling is allowed, an idle stretch with push
    // low may come first.
    task automatic send_request(input int hh, input int mm, input int ss,
                                input int y, input int col);
        int gap;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push <= 1'b1;
        hours <= 5'(hh);
        minutes <= 6'(mm);
        seconds <= 6'(ss);
        row <= 9'(y);
        byte_column <= 7'(col);
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        requests_sent++;
    endtask

    // A random request. Three in four aim at the text band and the columns the
    // string covers, a little beyond each edge, since everything else renders
    // blank; the rest are drawn from the whole field range, off-screen rows
    // and columns included. Time fields now and then go past their normal
    // range up to the field maximum.
    task automatic random_request();
        int s;
        int y0;
        int x0;
        int hh;
        int mm;
        int ss;
        int y;
        int col;
        s = clamp_scale(cur_scale);
        y0 = band_top(s);
        x0 = text_left(s);
        hh = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
        mm = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 59);
        ss = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 59);
        if ($urandom_range(0, 3) != 0)
        begin
            y = $urandom_range(y0 - 2, y0 + 7 * s + 1);
            col = $urandom_range(byte_of_pixel(x0 - 4), byte_of_pixel(x0 + 43 * s + 4));
        end
        else
        begin
            y = $urandom_range(0, 511);
            col = $urandom_range(0, 127);
        end
        send_request(hh, mm, ss, y, col);
    endtask

    // Random requests in chunks of 24; each chunk decides afresh whether the
    // two sides may idle, so stretches without any idling occur too. The last
    // phase of the run never idles.
    task automatic random_run(input int count, input bit no_idle);
        for (int i = 0; i < count; i++)
        begin
            if (i % 24 == 0)
            begin
                idle_en = no_idle ? 1'b0 : ($urandom_range(0, 3) != 0);
            end
            random_request();
        end
    endtask

    // Stops sending and waits until every request has its result back, so
    // the block is idle and the scale may be changed.
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_scale(input int raw);
        @(negedge clk);
        cfg_valid <= 1'b1;
        glyph_scale <= 5'(raw);
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_scale = raw;
        settings_used++;
    endtask

    // Directed requests at the reset scale: all-zero and all-one fields, the
    // last on-screen row and column, rows and columns just off the screen,
    // every font row through the text with every digit shown, time fields
    // beyond their normal range drawn inside the text, the rows just outside
    // and on the edges of the text band, and the string's edge columns.
    task automatic directed_requests();
        int s;
        int y0;
        int x0;
        bit odd;
        s = clamp_scale(cur_scale);
        y0 = band_top(s);
        x0 = text_left(s);
        send_request(0, 0, 0, 0, 0);
        send_request(31, 63, 63, 511, 127);
        send_request(23, 59, 59, DISPLAY_HEIGHT - 1, DISPLAY_WIDTH / 8 - 1);
        send_request(23, 59, 59, DISPLAY_HEIGHT, 50);
        send_request(12, 34, 56, y0 + 3 * s, DISPLAY_WIDTH / 8);
        send_request(12, 34, 56, y0 + 3 * s, 127);
        // One request per font row, walking across the slots; 06:17:28 and
        // 19:39:49 between them show the digits other than 5, which the band
        // edge requests below bring in.
        for (int k = 0; k < 7; k++)
        begin
            odd = (k % 2 == 1);
            send_request(odd ? 19 : 6, odd ? 39 : 17, odd ? 49 : 28,
                         y0 + k * s + (k * 3) % s, byte_of_pixel(x0 + k * 6 * s + 2 * s));
        end
        send_request(31, 63, 63, y0 + 3 * s, byte_of_pixel(x0 + 2 * s));
        send_request(31, 63, 63, y0 + 5 * s, byte_of_pixel(x0 + 18 * s));
        send_request(23, 45, 50, y0 - 1, byte_of_pixel(x0 + 21 * s));
        send_request(23, 45, 50, y0, byte_of_pixel(x0 + 21 * s));
        send_request(23, 45, 50, y0 + 7 * s - 1, byte_of_pixel(x0 + 21 * s));
        send_request(23, 45, 50, y0 + 7 * s, byte_of_pixel(x0 + 21 * s));
        send_request(8, 8, 8, y0 + 2 * s, byte_of_pixel(x0));
        send_request(8, 8, 8, y0 + 2 * s, byte_of_pixel(x0 + 43 * s - 1));
    endtask

    // Watchdog: ends the run if nothing at all is accepted for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t: no request, result or scale write accepted for %0d cycles",
                 $time, STALL_LIMIT);
        $display("FAIL scaled_clock_text_pixel_generator_core");
        $finish;
    end

    initial
    begin : stimulus
        int phase_scales [NUM_PHASES];
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        glyph_scale = '0;
        push = 1'b0;
        hours = '0;
        minutes = '0;
        seconds = '0;
        row = '0;
        byte_column = '0;
        idle_en = 1'b1;
        requests_sent = 0;
        settings_used = 1;
        cur_scale = SCALE_RESET;

        // Scale settings after the reset value: both bounds, values below and
        // above the range (all-zero and all-one among them), then one random
        // raw value and one random in-range value.
        phase_scales = '{SCALE_LO, SCALE_HI, 0, 31, SCALE_LO - 1, SCALE_HI + 1, 0, 0};
        phase_scales[6] = $urandom_range(0, 31);
        phase_scales[7] = $urandom_range(SCALE_LO, SCALE_HI);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The reset scale is exercised before the register is ever written.
        directed_requests();
        random_run(60, 1'b0);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_scale(phase_scales[p]);
            random_run(72, p == NUM_PHASES - 1);
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d pixel byte requests over %0d scale settings, clamped ones included.",
                 requests_sent, settings_used);
        $display("Checked %0d result bytes, %0d of them with ink, %0d mismatches.",
                 bytes_checked, inked_bytes, mismatch_count);
        if (mismatch_count == 0 && outstanding == 0)
        begin
            $display("PASS scaled_clock_text_pixel_generator_core");
        end
        else
        begin
            $display("FAIL scaled_clock_text_pixel_generator_core");
        end
        $finish;
    end

endmodule
